### sv/ball_ground_position_unit_assert.svh
// ---------------------------------------------------------------------------
// ball ground position assertion macros
// concurrent checks shared by the ball ground position modules
// ---------------------------------------------------------------------------
`ifndef BALL_GROUND_POSITION_UNIT_ASSERT_SVH
`define BALL_GROUND_POSITION_UNIT_ASSERT_SVH

// same-cycle implication, clocked on i_clk, quiet during reset
`define BGPU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ball ground position: same-cycle check failed");

// next-cycle implication, clocked on i_clk, quiet during reset
`define BGPU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ball ground position: next-cycle check failed");

`endif

### sv/bgp_pkg.sv
// ---------------------------------------------------------------------------
// ball ground position package
// shared constants, types and helper functions of the ground position pipe
// ---------------------------------------------------------------------------
`default_nettype none

package bgp_pkg;

    // default frame size in pixels
    localparam int FRAME_COLS_DEF = 640;
    localparam int FRAME_ROWS_DEF = 480;

    // pi/2 in 2^-20 rad and the cordic start vector in q30
    localparam int HALF_PI   = 1647099;
    localparam int CORDIC_K  = 652032874;
    localparam int CORDIC_N  = 20;
    localparam int DIV_BITS  = 23;

    // widths
    localparam int ANG_W  = 18;
    localparam int MM_W   = 24;
    localparam int TRIG_W = 33;
    localparam int Z_W    = 26;
    localparam int W_W    = 22;
    localparam int NUM_W  = 48;
    localparam int DIVD_W = 49;
    localparam int DIVS_W = 33;
    localparam int REM_W  = DIVS_W + DIV_BITS;

    typedef logic signed [TRIG_W-1:0] t_trig;
    typedef logic signed [ANG_W-1:0]  t_ang;
    typedef logic signed [MM_W-1:0]   t_mm;

    // register indexes of the configuration port
    typedef enum logic [2:0] {
        CFG_PAN_PER_PIXEL  = 3'd0,
        CFG_TILT_PER_PIXEL = 3'd1,
        CFG_BASE_PAN       = 3'd2,
        CFG_BASE_TILT      = 3'd3,
        CFG_LENS_HEIGHT    = 3'd4,
        CFG_SPHERE_RADIUS  = 3'd5,
        CFG_MOUNT_OFFSET_X = 3'd6,
        CFG_MOUNT_OFFSET_Y = 3'd7
    } t_cfg_idx;

    // values travelling alongside the divider
    typedef struct packed {
        logic signed [ANG_W-1:0] bearing;
        logic signed [ANG_W-1:0] slope;
        logic signed [TRIG_W-1:0] cb;
        logic signed [TRIG_W-1:0] sb;
        logic neg;
        logic zero;
    } t_side;

    // arctangent of 2^-i in 2^-20 rad
    function automatic logic [20:0] atan_val(input int i);
        logic [20:0] v;
        v = '0;
        case (i)
            0:  v = 21'd823550;
            1:  v = 21'd486170;
            2:  v = 21'd256879;
            3:  v = 21'd130396;
            4:  v = 21'd65451;
            5:  v = 21'd32757;
            6:  v = 21'd16383;
            7:  v = 21'd8192;
            8:  v = 21'd4096;
            9:  v = 21'd2048;
            10: v = 21'd1024;
            11: v = 21'd512;
            12: v = 21'd256;
            13: v = 21'd128;
            14: v = 21'd64;
            15: v = 21'd32;
            16: v = 21'd16;
            17: v = 21'd8;
            18: v = 21'd4;
            19: v = 21'd2;
            default: v = '0;
        endcase
        return v;
    endfunction

    // floor of v over pi/2 by parallel threshold compares, result -10 to 10
    function automatic logic signed [4:0] quad_index(input logic signed [Z_W-1:0] v);
        logic [4:0]        cnt;
        logic signed [5:0] kk;
        cnt = '0;
        for (int j = -9; j <= 10; j++) begin
            if (v >= j * HALF_PI) begin
                cnt = cnt + 5'd1;
            end
        end
        kk = $signed({1'b0, cnt}) - 6'sd10;
        return kk[4:0];
    endfunction

endpackage

`default_nettype wire

### sv/bgp_cordic.sv
// ---------------------------------------------------------------------------
// bgp cordic lane
// quadrant reduction and a 20 stage rotation cordic giving cos and sin in q30
// ---------------------------------------------------------------------------
`default_nettype none

module bgp_cordic (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  wire logic                              i_valid,
    input  wire logic signed [bgp_pkg::ANG_W-1:0]  i_angle,
    output logic                                   o_valid,
    output logic signed [bgp_pkg::ANG_W-1:0]       o_angle,
    output bgp_pkg::t_trig                         o_cos,
    output bgp_pkg::t_trig                         o_sin
);

    localparam int N = bgp_pkg::CORDIC_N;

    // reduction stage a: scale and quadrant index
    logic                              r_a_v;
    logic signed [bgp_pkg::Z_W-1:0]    r_a_z;
    logic signed [4:0]                 r_a_k;
    logic signed [bgp_pkg::ANG_W-1:0]  r_a_ang;
    logic signed [bgp_pkg::Z_W-1:0]    n_a_z;

    always_comb begin
        n_a_z = bgp_pkg::Z_W'(i_angle) <<< 7;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_z   <= n_a_z;
            r_a_k   <= bgp_pkg::quad_index(n_a_z + bgp_pkg::Z_W'(bgp_pkg::HALF_PI / 2));
            r_a_ang <= i_angle;
        end
    end

    // reduction stage b: residual angle
    logic                              r_b_v;
    logic signed [bgp_pkg::W_W-1:0]    r_b_w;
    logic [1:0]                        r_b_q;
    logic signed [bgp_pkg::ANG_W-1:0]  r_b_ang;
    logic signed [bgp_pkg::Z_W-1:0]    n_b_kp;
    logic signed [bgp_pkg::Z_W-1:0]    n_b_w;

    always_comb begin
        n_b_kp = r_a_k * $signed(bgp_pkg::Z_W'(bgp_pkg::HALF_PI));
        n_b_w  = r_a_z - n_b_kp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (i_en) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_w   <= n_b_w[bgp_pkg::W_W-1:0];
            r_b_q   <= r_a_k[1:0];
            r_b_ang <= r_a_ang;
        end
    end

    // rotation stages
    bgp_pkg::t_trig                    r_x   [1:N];
    bgp_pkg::t_trig                    r_y   [1:N];
    logic signed [bgp_pkg::W_W-1:0]    r_w   [1:N];
    logic [1:0]                        r_q   [1:N];
    logic signed [bgp_pkg::ANG_W-1:0]  r_ang [1:N];
    logic [N:1]                        r_v;

    for (genvar i = 0; i < N; i++) begin : g_step
        bgp_pkg::t_trig                  s_x;
        bgp_pkg::t_trig                  s_y;
        logic signed [bgp_pkg::W_W-1:0]  s_w;
        logic [1:0]                      s_q;
        logic signed [bgp_pkg::ANG_W-1:0] s_ang;
        logic                            s_v;
        bgp_pkg::t_trig                  n_x;
        bgp_pkg::t_trig                  n_y;
        logic signed [bgp_pkg::W_W-1:0]  n_w;
        logic signed [bgp_pkg::W_W-1:0]  c_atan;

        if (i == 0) begin : g_first
            assign s_x   = bgp_pkg::TRIG_W'(bgp_pkg::CORDIC_K);
            assign s_y   = '0;
            assign s_w   = r_b_w;
            assign s_q   = r_b_q;
            assign s_ang = r_b_ang;
            assign s_v   = r_b_v;
        end else begin : g_next
            assign s_x   = r_x[i];
            assign s_y   = r_y[i];
            assign s_w   = r_w[i];
            assign s_q   = r_q[i];
            assign s_ang = r_ang[i];
            assign s_v   = r_v[i];
        end

        assign c_atan = $signed(bgp_pkg::W_W'(bgp_pkg::atan_val(i)));

        // one micro-rotation, direction from the sign of the residual
        always_comb begin
            if (s_w >= 0) begin
                n_x = s_x - (s_y >>> i);
                n_y = s_y + (s_x >>> i);
                n_w = s_w - c_atan;
            end else begin
                n_x = s_x + (s_y >>> i);
                n_y = s_y - (s_x >>> i);
                n_w = s_w + c_atan;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1] <= s_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i+1]   <= n_x;
                r_y[i+1]   <= n_y;
                r_w[i+1]   <= n_w;
                r_q[i+1]   <= s_q;
                r_ang[i+1] <= s_ang;
            end
        end
    end

    // quadrant rotation of the final vector
    logic                              r_o_v;
    bgp_pkg::t_trig                    r_o_cos;
    bgp_pkg::t_trig                    r_o_sin;
    logic signed [bgp_pkg::ANG_W-1:0]  r_o_ang;
    bgp_pkg::t_trig                    n_o_cos;
    bgp_pkg::t_trig                    n_o_sin;

    always_comb begin
        unique case (r_q[N])
            2'd0: begin
                n_o_cos = r_x[N];
                n_o_sin = r_y[N];
            end
            2'd1: begin
                n_o_cos = -r_y[N];
                n_o_sin = r_x[N];
            end
            2'd2: begin
                n_o_cos = -r_x[N];
                n_o_sin = -r_y[N];
            end
            default: begin
                n_o_cos = r_y[N];
                n_o_sin = -r_x[N];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (i_en) begin
            r_o_v <= r_v[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_o_cos <= n_o_cos;
            r_o_sin <= n_o_sin;
            r_o_ang <= r_ang[N];
        end
    end

    assign o_valid = r_o_v;
    assign o_angle = r_o_ang;
    assign o_cos   = r_o_cos;
    assign o_sin   = r_o_sin;

endmodule

`default_nettype wire

### sv/bgp_divider.sv
// ---------------------------------------------------------------------------
// bgp divider
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// ---------------------------------------------------------------------------
`default_nettype none

module bgp_divider (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic [bgp_pkg::DIVD_W-1:0]    i_num,
    input  wire logic [bgp_pkg::DIVS_W-1:0]    i_den,
    input  wire bgp_pkg::t_side                i_side,
    output logic                               o_valid,
    output logic [bgp_pkg::DIV_BITS-1:0]       o_quot,
    output logic                               o_ovf,
    output bgp_pkg::t_side                     o_side
);

    localparam int NB = bgp_pkg::DIV_BITS;
    localparam int RW = bgp_pkg::REM_W;

    logic [NB:0]                    r_v;
    logic [RW-1:0]                  r_rem  [0:NB];
    logic [bgp_pkg::DIVS_W-1:0]     r_den  [0:NB];
    logic [NB-1:0]                  r_q    [0:NB];
    logic                           r_ovf  [0:NB];
    bgp_pkg::t_side                 r_side [0:NB];

    // entry stage: quotient overflow check against divisor shifted by all bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= RW'(i_num);
            r_den[0]  <= i_den;
            r_q[0]    <= '0;
            r_ovf[0]  <= RW'(i_num) >= {i_den, {NB{1'b0}}};
            r_side[0] <= i_side;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar s = 1; s <= NB; s++) begin : g_bit
        localparam int B = NB - s;
        logic [RW-1:0] c_trial;
        logic          c_take;

        assign c_trial = RW'(r_den[s-1]) << B;
        assign c_take  = r_rem[s-1] >= c_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= r_v[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= c_take ? (r_rem[s-1] - c_trial) : r_rem[s-1];
                r_q[s]    <= r_q[s-1] | (NB'(c_take) << B);
                r_den[s]  <= r_den[s-1];
                r_ovf[s]  <= r_ovf[s-1];
                r_side[s] <= r_side[s-1];
            end
        end
    end

    assign o_valid = r_v[NB];
    assign o_quot  = r_q[NB];
    assign o_ovf   = r_ovf[NB];
    assign o_side  = r_side[NB];

    `include "ball_ground_position_unit_assert.svh"

    // a finished division leaves a remainder below the divisor
    `BGPU_ASSERT_NOW(a_rem_below_den, r_v[NB] && !r_ovf[NB], r_rem[NB] < RW'(r_den[NB]))
    // a zero divisor always takes the overflow path
    `BGPU_ASSERT_NOW(a_zero_den_ovf, r_v[0] && (r_den[0] == '0), r_ovf[0])
    // a held pipe keeps every valid bit
    `BGPU_ASSERT_NEXT(a_hold_valid, !i_en && i_rst_n, $stable(r_v))

endmodule

`default_nettype wire

### sv/ball_ground_position_unit.sv
// ---------------------------------------------------------------------------
// ball ground position unit
// bearing, slope, ground distance and ground x/y of a ball seen by a
// pan/tilt camera, as a fully pipelined datapath
// ---------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  input     in         i_valid / o_stall         centre x/y, pan, tilt
//  result    out        o_valid / i_stall         bearing .. position_valid
//  config    in         i_cfg_valid / o_cfg_ready index, data
//
//  one transaction enters per cycle while o_stall is low; each result passes through
//  the 20 stage cordic lanes and the 23 quotient-bit stages of the restoring divider
//  a stalled result holds the whole pipe, input stall follows at once
//  reset is synchronous and clears the valid bits and the configuration registers
// ---------------------------------------------------------------------------
`default_nettype none

module ball_ground_position_unit #(
    parameter int FRAME_COLS = bgp_pkg::FRAME_COLS_DEF,
    parameter int FRAME_ROWS = bgp_pkg::FRAME_ROWS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input channel
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [11:0]           i_center_x,
    input  wire logic [11:0]           i_center_y,
    input  wire logic signed [15:0]    i_pan_angle,
    input  wire logic signed [15:0]    i_tilt_angle,
    // result channel
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic signed [17:0]         o_bearing,
    output logic signed [17:0]         o_slope,
    output logic signed [23:0]         o_ground_distance,
    output logic signed [23:0]         o_ground_x,
    output logic signed [23:0]         o_ground_y,
    output logic                       o_position_valid,
    // configuration channel
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [2:0]            i_cfg_index,
    input  wire logic [15:0]           i_cfg_data
);

    localparam int CX_OFF = 4 * (FRAME_COLS / 2);
    localparam int CY_OFF = 4 * (FRAME_ROWS / 2);
    localparam int MM_W   = bgp_pkg::MM_W;
    localparam int ANG_W  = bgp_pkg::ANG_W;

    localparam logic signed [21:0] ANG_MAX = 22'sd131071;
    localparam logic signed [21:0] ANG_MIN = -22'sd131072;
    localparam logic signed [27:0] MM_MAX  = 28'sd8388607;
    localparam logic signed [27:0] MM_MIN  = -28'sd8388608;

    // configuration registers
    logic [15:0]         r_pan_per_pixel;
    logic [15:0]         r_tilt_per_pixel;
    logic signed [15:0]  r_base_pan;
    logic signed [15:0]  r_base_tilt;
    logic [12:0]         r_lens_height;
    logic [9:0]          r_sphere_radius;
    logic signed [12:0]  r_mount_offset_x;
    logic signed [12:0]  r_mount_offset_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pan_per_pixel  <= 16'd1200;
            r_tilt_per_pixel <= 16'd1200;
            r_base_pan       <= '0;
            r_base_tilt      <= '0;
            r_lens_height    <= 13'd500;
            r_sphere_radius  <= 10'd110;
            r_mount_offset_x <= '0;
            r_mount_offset_y <= '0;
        end else if (i_cfg_valid) begin
            unique case (bgp_pkg::t_cfg_idx'(i_cfg_index))
                bgp_pkg::CFG_PAN_PER_PIXEL:  r_pan_per_pixel  <= i_cfg_data;
                bgp_pkg::CFG_TILT_PER_PIXEL: r_tilt_per_pixel <= i_cfg_data;
                bgp_pkg::CFG_BASE_PAN:       r_base_pan       <= $signed(i_cfg_data);
                bgp_pkg::CFG_BASE_TILT:      r_base_tilt      <= $signed(i_cfg_data);
                bgp_pkg::CFG_LENS_HEIGHT:    r_lens_height    <= i_cfg_data[12:0];
                bgp_pkg::CFG_SPHERE_RADIUS:  r_sphere_radius  <= i_cfg_data[9:0];
                bgp_pkg::CFG_MOUNT_OFFSET_X: r_mount_offset_x <= $signed(i_cfg_data[12:0]);
                bgp_pkg::CFG_MOUNT_OFFSET_Y: r_mount_offset_y <= $signed(i_cfg_data[12:0]);
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // global advance: the pipe moves unless a finished result is held
    logic r_out_v;
    logic en;

    assign en      = !(r_out_v && i_stall);
    assign o_stall = r_out_v && i_stall;

    // stage 1: pixel offsets times angle per pixel
    logic               r1_v;
    logic signed [29:0] r1_px;
    logic signed [29:0] r1_py;
    logic signed [15:0] r1_pan;
    logic signed [15:0] r1_tilt;
    logic signed [12:0] c1_dx;
    logic signed [12:0] c1_dy;
    logic signed [29:0] n1_px;
    logic signed [29:0] n1_py;

    always_comb begin
        c1_dx = $signed({1'b0, i_center_x}) - $signed(13'(CX_OFF));
        c1_dy = $signed(13'(CY_OFF)) - $signed({1'b0, i_center_y});
        n1_px = c1_dx * $signed({1'b0, r_pan_per_pixel});
        n1_py = c1_dy * $signed({1'b0, r_tilt_per_pixel});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_px   <= n1_px;
            r1_py   <= n1_py;
            r1_pan  <= i_pan_angle;
            r1_tilt <= i_tilt_angle;
        end
    end

    // stage 2: round to 2^-13 rad, add camera angles, negate the bearing, saturate
    logic               r2_v;
    logic signed [17:0] r2_bearing;
    logic signed [17:0] r2_slope;
    logic signed [29:0] c2_rx;
    logic signed [29:0] c2_ry;
    logic signed [21:0] c2_bsum;
    logic signed [21:0] c2_ssum;
    logic signed [21:0] c2_bneg;
    logic signed [17:0] n2_bearing;
    logic signed [17:0] n2_slope;

    always_comb begin
        c2_rx   = (r1_px + 30'sd256) >>> 9;
        c2_ry   = (r1_py + 30'sd256) >>> 9;
        c2_bsum = 22'(c2_rx) + 22'(r1_pan) + 22'(r_base_pan);
        c2_ssum = 22'(c2_ry) + 22'(r1_tilt) + 22'(r_base_tilt);
        c2_bneg = -c2_bsum;
        priority if (c2_bneg > ANG_MAX) n2_bearing = ANG_MAX[ANG_W-1:0];
        else if (c2_bneg < ANG_MIN)     n2_bearing = ANG_MIN[ANG_W-1:0];
        else                            n2_bearing = c2_bneg[ANG_W-1:0];
        priority if (c2_ssum > ANG_MAX) n2_slope = ANG_MAX[ANG_W-1:0];
        else if (c2_ssum < ANG_MIN)     n2_slope = ANG_MIN[ANG_W-1:0];
        else                            n2_slope = c2_ssum[ANG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_bearing <= n2_bearing;
            r2_slope   <= n2_slope;
        end
    end

    // cordic lanes for slope and bearing, run in lockstep
    logic               cs_v;
    logic               cb_v;
    logic signed [17:0] cs_ang;
    logic signed [17:0] cb_ang;
    bgp_pkg::t_trig     cs_cos;
    bgp_pkg::t_trig     cs_sin;
    bgp_pkg::t_trig     cb_cos;
    bgp_pkg::t_trig     cb_sin;

    bgp_cordic u_cordic_slope (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r2_v),
        .i_angle (r2_slope),
        .o_valid (cs_v),
        .o_angle (cs_ang),
        .o_cos   (cs_cos),
        .o_sin   (cs_sin)
    );

    bgp_cordic u_cordic_bearing (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r2_v),
        .i_angle (r2_bearing),
        .o_valid (cb_v),
        .o_angle (cb_ang),
        .o_cos   (cb_cos),
        .o_sin   (cb_sin)
    );

    // stage 3: numerator -(h - r) * cos(slope)
    logic                   r3_v;
    logic signed [47:0]     r3_num;
    bgp_pkg::t_trig         r3_s;
    bgp_pkg::t_side         r3_side;
    logic signed [13:0]     c3_hr;

    always_comb begin
        c3_hr = $signed({1'b0, r_lens_height}) - $signed({4'b0, r_sphere_radius});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= cs_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_num          <= -(c3_hr * cs_cos);
            r3_s            <= cs_sin;
            r3_side.bearing <= cb_ang;
            r3_side.slope   <= cs_ang;
            r3_side.cb      <= cb_cos;
            r3_side.sb      <= cb_sin;
            r3_side.neg     <= 1'b0;
            r3_side.zero    <= 1'b0;
        end
    end

    // stage 4: magnitudes and rounding offset, sign and horizon flags
    logic                               r4_v;
    logic [bgp_pkg::DIVD_W-1:0]         r4_num;
    logic [bgp_pkg::DIVS_W-1:0]         r4_den;
    bgp_pkg::t_side                     r4_side;
    logic [47:0]                        c4_an;
    logic [32:0]                        c4_ad;
    bgp_pkg::t_side                     n4_side;

    always_comb begin
        c4_an        = r3_num[47] ? 48'(-r3_num) : 48'(r3_num);
        c4_ad        = r3_s[32] ? 33'(-r3_s) : 33'(r3_s);
        n4_side      = r3_side;
        n4_side.neg  = r3_num[47] != r3_s[32];
        n4_side.zero = (r3_num == '0) && (r3_s == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_num  <= {c4_an, 1'b0} + bgp_pkg::DIVD_W'(c4_ad);
            r4_den  <= {c4_ad[31:0], 1'b0};
            r4_side <= n4_side;
        end
    end

    // rounded quotient |2n| + |s| over |2s|
    logic                           dv_v;
    logic [bgp_pkg::DIV_BITS-1:0]   dv_q;
    logic                           dv_ovf;
    bgp_pkg::t_side                 dv_side;

    bgp_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r4_v),
        .i_num   (r4_num),
        .i_den   (r4_den),
        .i_side  (r4_side),
        .o_valid (dv_v),
        .o_quot  (dv_q),
        .o_ovf   (dv_ovf),
        .o_side  (dv_side)
    );

    // stage 5: signed, saturated distance
    logic               r5_v;
    logic signed [23:0] r5_dist;
    bgp_pkg::t_side     r5_side;
    logic signed [23:0] n5_dist;

    always_comb begin
        priority if (dv_side.zero) n5_dist = '0;
        else if (dv_ovf)           n5_dist = dv_side.neg ? MM_MIN[MM_W-1:0] : MM_MAX[MM_W-1:0];
        else if (dv_side.neg)      n5_dist = -$signed({1'b0, dv_q});
        else                       n5_dist = $signed({1'b0, dv_q});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (en) begin
            r5_v <= dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_dist <= n5_dist;
            r5_side <= dv_side;
        end
    end

    // stage 6: distance times cos and sin of the bearing
    logic               r6_v;
    logic signed [56:0] r6_px;
    logic signed [56:0] r6_py;
    logic signed [23:0] r6_dist;
    logic signed [17:0] r6_bearing;
    logic signed [17:0] r6_slope;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (en) begin
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_px      <= r5_side.cb * r5_dist;
            r6_py      <= r5_side.sb * r5_dist;
            r6_dist    <= r5_dist;
            r6_bearing <= r5_side.bearing;
            r6_slope   <= r5_side.slope;
        end
    end

    // stage 7: round from q30, add mount offsets, saturate into the result register
    logic               r_out_pv;
    logic signed [17:0] r_out_bearing;
    logic signed [17:0] r_out_slope;
    logic signed [23:0] r_out_dist;
    logic signed [23:0] r_out_gx;
    logic signed [23:0] r_out_gy;
    logic signed [56:0] c7_rx;
    logic signed [56:0] c7_ry;
    logic signed [27:0] c7_gx;
    logic signed [27:0] c7_gy;
    logic signed [23:0] n7_gx;
    logic signed [23:0] n7_gy;

    always_comb begin
        c7_rx = (r6_px + 57'sd536870912) >>> 30;
        c7_ry = (r6_py + 57'sd536870912) >>> 30;
        c7_gx = c7_rx[27:0] + 28'(r_mount_offset_x);
        c7_gy = c7_ry[27:0] + 28'(r_mount_offset_y);
        priority if (c7_gx > MM_MAX) n7_gx = MM_MAX[MM_W-1:0];
        else if (c7_gx < MM_MIN)     n7_gx = MM_MIN[MM_W-1:0];
        else                         n7_gx = c7_gx[MM_W-1:0];
        priority if (c7_gy > MM_MAX) n7_gy = MM_MAX[MM_W-1:0];
        else if (c7_gy < MM_MIN)     n7_gy = MM_MIN[MM_W-1:0];
        else                         n7_gy = c7_gy[MM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_bearing <= r6_bearing;
            r_out_slope   <= r6_slope;
            r_out_dist    <= r6_dist;
            r_out_gx      <= n7_gx;
            r_out_gy      <= n7_gy;
            r_out_pv      <= r6_dist > 24'sd0;
        end
    end

    assign o_valid           = r_out_v;
    assign o_bearing         = r_out_bearing;
    assign o_slope           = r_out_slope;
    assign o_ground_distance = r_out_dist;
    assign o_ground_x        = r_out_gx;
    assign o_ground_y        = r_out_gy;
    assign o_position_valid  = r_out_pv;

    `include "ball_ground_position_unit_assert.svh"

    // the two cordic lanes stay in step
    `BGPU_ASSERT_NOW(a_lanes_aligned, 1'b1, cs_v == cb_v)
    // a held result keeps the result valid
    `BGPU_ASSERT_NEXT(a_held_result, r_out_v && i_stall, r_out_v)
    // input is only held back while a result is waiting
    `BGPU_ASSERT_NOW(a_stall_cause, o_stall, r_out_v)

endmodule

`default_nettype wire

### sim/ball_ground_position_unit_test.sv
// ---------------------------------------------------------------------------
// ball ground position unit testbench
// drives detections through the pipe under random gaps and stalls, predicts
// bearing, slope, distance and ground x/y for each transaction and compares
// every result in order; registers are rewritten between phases while idle
// ---------------------------------------------------------------------------
`default_nettype none

module ball_ground_position_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  IMG_W      = bgp_pkg::FRAME_COLS_DEF;
    localparam int  IMG_H      = bgp_pkg::FRAME_ROWS_DEF;
    localparam int  DRAIN_WAIT = 80;
    localparam int  QUIET_MAX  = 20000;
    localparam int  HOLD_LEN   = 300;
    localparam longint Q_HALF_PI = 1647099;
    localparam longint Q_GAIN    = 652032874;
    localparam longint ANG_HI = 131071;
    localparam longint ANG_LO = -131072;
    localparam longint MM_HI  = 8388607;
    localparam longint MM_LO  = -8388608;

    typedef struct {
        logic signed [17:0] bearing;
        logic signed [17:0] slope;
        logic signed [23:0] gdist;
        logic signed [23:0] gx;
        logic signed [23:0] gy;
        logic               on_ground;
    } t_ground_fix;

    typedef struct {
        logic [11:0]        cx;
        logic [11:0]        cy;
        logic signed [15:0] pan;
        logic signed [15:0] tilt;
        bit                 typed;
        logic signed [17:0] bearing;
        logic signed [17:0] slope;
    } t_detection;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [11:0]        i_center_x = '0;
    logic [11:0]        i_center_y = '0;
    logic signed [15:0] i_pan_angle = '0;
    logic signed [15:0] i_tilt_angle = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [17:0] o_bearing;
    logic signed [17:0] o_slope;
    logic signed [23:0] o_ground_distance;
    logic signed [23:0] o_ground_x;
    logic signed [23:0] o_ground_y;
    logic               o_position_valid;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [15:0]        i_cfg_data = '0;

    ball_ground_position_unit dut (.*);

    // register shadow
    logic [15:0]        sh_pan_pp = 16'd1200;
    logic [15:0]        sh_tilt_pp = 16'd1200;
    logic signed [15:0] sh_base_pan = '0;
    logic signed [15:0] sh_base_tilt = '0;
    logic [12:0]        sh_height = 13'd500;
    logic [9:0]         sh_radius = 10'd110;
    logic signed [12:0] sh_off_x = '0;
    logic signed [12:0] sh_off_y = '0;

    t_ground_fix fix_q[$];
    int  errors = 0;
    int  n_items = 0;
    int  n_results = 0;
    int  n_on_ground = 0;
    bit  quiet = 1'b0;
    bit  hold_req = 1'b0;
    longint arctan_steps[20] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383,
                                 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8,
                                 4, 2};

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // angle in 2^-13 rad to cosine and sine in q30
    function automatic void rotate_angle(input longint a13, output longint c,
                                         output longint s);
        longint z, k, w, x, y, xs, ys;
        z = a13 * 128;
        k = z + Q_HALF_PI / 2;
        k = (k >= 0) ? k / Q_HALF_PI : -((-k + Q_HALF_PI - 1) / Q_HALF_PI);
        w = z - k * Q_HALF_PI;
        x = Q_GAIN;
        y = 0;
        for (int i = 0; i < 20; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (w >= 0) begin
                x = x - ys; y = y + xs; w = w - arctan_steps[i];
            end else begin
                x = x + ys; y = y - xs; w = w + arctan_steps[i];
            end
        end
        case (k[1:0])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    // ground position of one detection under the current registers
    function automatic t_ground_fix locate_ball(t_detection d);
        t_ground_fix f;
        longint dx, dy, brg, slp, cs, ss, cb, sb, num, an, ad, q, gdist, gx, gy;
        dx  = longint'(d.cx) - 4 * (IMG_W / 2);
        dy  = 4 * (IMG_H / 2) - longint'(d.cy);
        brg = -(((dx * longint'(sh_pan_pp) + 256) >>> 9) + longint'(d.pan)
                + longint'(sh_base_pan));
        brg = clamp(brg, ANG_LO, ANG_HI);
        slp = ((dy * longint'(sh_tilt_pp) + 256) >>> 9) + longint'(d.tilt)
              + longint'(sh_base_tilt);
        slp = clamp(slp, ANG_LO, ANG_HI);
        rotate_angle(slp, cs, ss);
        num = -(longint'(sh_height) - longint'(sh_radius)) * cs;
        if (ss == 0) begin
            gdist = num > 0 ? MM_HI : (num < 0 ? MM_LO : 0);
        end else begin
            an    = num < 0 ? -num : num;
            ad    = ss < 0 ? -ss : ss;
            q     = (2 * an + ad) / (2 * ad);
            gdist = clamp(((num < 0) != (ss < 0)) ? -q : q, MM_LO, MM_HI);
        end
        rotate_angle(brg, cb, sb);
        gx = ((cb * gdist + (64'sd1 <<< 29)) >>> 30) + longint'(sh_off_x);
        gy = ((sb * gdist + (64'sd1 <<< 29)) >>> 30) + longint'(sh_off_y);
        f.bearing   = 18'(brg);
        f.slope     = 18'(slp);
        f.gdist     = 24'(gdist);
        f.gx        = 24'(clamp(gx, MM_LO, MM_HI));
        f.gy        = 24'(clamp(gy, MM_LO, MM_HI));
        f.on_ground = gdist > 0;
        return f;
    endfunction

    // idle cycles before the next transaction: mostly none, some short, few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_detection(t_detection d);
        t_ground_fix f;
        int gap;
        i_valid      <= 1'b1;
        i_center_x   <= d.cx;
        i_center_y   <= d.cy;
        i_pan_angle  <= d.pan;
        i_tilt_angle <= d.tilt;
        do @(posedge i_clk); while (o_stall);
        f = locate_ball(d);
        if (d.typed) begin
            f.bearing = d.bearing;
            f.slope   = d.slope;
        end
        fix_q.push_back(f);
        n_items++;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(bgp_pkg::t_cfg_idx idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            bgp_pkg::CFG_PAN_PER_PIXEL:  sh_pan_pp    = data;
            bgp_pkg::CFG_TILT_PER_PIXEL: sh_tilt_pp   = data;
            bgp_pkg::CFG_BASE_PAN:       sh_base_pan  = data;
            bgp_pkg::CFG_BASE_TILT:      sh_base_tilt = data;
            bgp_pkg::CFG_LENS_HEIGHT:    sh_height    = data[12:0];
            bgp_pkg::CFG_SPHERE_RADIUS:  sh_radius    = data[9:0];
            bgp_pkg::CFG_MOUNT_OFFSET_X: sh_off_x     = data[12:0];
            default:                     sh_off_y     = data[12:0];
        endcase
    endtask

    task automatic drain_pipe();
        while (fix_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // random detection: mostly a ball in view below the horizon, else anything
    function automatic t_detection random_detection();
        t_detection d;
        d.typed = 1'b0;
        d.bearing = '0;
        d.slope = '0;
        if ($urandom_range(0, 9) < 7) begin
            d.cx   = 12'($urandom_range(0, 4 * IMG_W - 1));
            d.cy   = 12'($urandom_range(0, 4 * IMG_H - 1));
            d.pan  = 16'(int'($urandom_range(0, 25736)) - 12868);
            d.tilt = 16'(int'($urandom_range(0, 13000)) - 12000);
        end else begin
            d.cx   = 12'($urandom);
            d.cy   = 12'($urandom);
            d.pan  = 16'($urandom);
            d.tilt = 16'($urandom);
        end
        return d;
    endfunction

    task automatic run_phase(int n, logic [15:0] ppp, logic [15:0] tpp, logic [15:0] bp,
                             logic [15:0] bt, logic [15:0] h, logic [15:0] r,
                             logic [15:0] ox, logic [15:0] oy);
        write_reg(bgp_pkg::CFG_PAN_PER_PIXEL, ppp);
        write_reg(bgp_pkg::CFG_TILT_PER_PIXEL, tpp);
        write_reg(bgp_pkg::CFG_BASE_PAN, bp);
        write_reg(bgp_pkg::CFG_BASE_TILT, bt);
        write_reg(bgp_pkg::CFG_LENS_HEIGHT, h);
        write_reg(bgp_pkg::CFG_SPHERE_RADIUS, r);
        write_reg(bgp_pkg::CFG_MOUNT_OFFSET_X, ox);
        write_reg(bgp_pkg::CFG_MOUNT_OFFSET_Y, oy);
        repeat (n) send_detection(random_detection());
        i_valid <= 1'b0;
        drain_pipe();
    endtask

    // result side: random stall, occasional long hold, and one requested hold
    always @(posedge i_clk) begin
        int hold_left;
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_LEN;
            i_stall <= 1'b1;
        end else if (quiet) begin
            i_stall <= 1'b0;
        end else if ($urandom_range(0, 199) == 0) begin
            hold_left = $urandom_range(20, 60);
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < 20);
        end
    end

    // result check against the oldest expectation
    always @(posedge i_clk) begin
        t_ground_fix e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (fix_q.size() == 0) begin
                $error("result transaction with nothing expected");
                errors++;
            end else begin
                e = fix_q.pop_front();
                n_results++;
                if (o_position_valid) n_on_ground++;
                if (o_bearing !== e.bearing) begin
                    $error("bearing: expected %0d, actual %0d", e.bearing, o_bearing);
                    errors++;
                end
                if (o_slope !== e.slope) begin
                    $error("slope: expected %0d, actual %0d", e.slope, o_slope);
                    errors++;
                end
                if (o_ground_distance !== e.gdist) begin
                    $error("ground_distance: expected %0d, actual %0d", e.gdist,
                           o_ground_distance);
                    errors++;
                end
                if (o_ground_x !== e.gx) begin
                    $error("ground_x: expected %0d, actual %0d", e.gx, o_ground_x);
                    errors++;
                end
                if (o_ground_y !== e.gy) begin
                    $error("ground_y: expected %0d, actual %0d", e.gy, o_ground_y);
                    errors++;
                end
                if (o_position_valid !== e.on_ground) begin
                    $error("position_valid: expected %0d, actual %0d", e.on_ground,
                           o_position_valid);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        int still;
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)
            || !i_rst_n) begin
            still = 0;
        end else begin
            still++;
            if (still >= QUIET_MAX) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // directed rows at reset registers; centre pixel gives a zero pixel term
    t_detection directed[] = '{
        '{12'd1280, 12'd960, 16'sd0,      16'sd0,      1'b1, 18'sd0,      18'sd0},
        '{12'd1280, 12'd960, 16'sd32767,  -16'sd32768, 1'b1, -18'sd32767, -18'sd32768},
        '{12'd1280, 12'd960, -16'sd32768, 16'sd32767,  1'b1, 18'sd32768,  18'sd32767},
        '{12'd1280, 12'd960, 16'sd12868,  -16'sd12868, 1'b1, -18'sd12868, -18'sd12868},
        '{12'd1280, 12'd960, -16'sd25736, -16'sd6434,  1'b1, 18'sd25736,  -18'sd6434},
        '{12'd1280, 12'd960, 16'sd0,      -16'sd1,     1'b1, 18'sd0,      -18'sd1},
        '{12'd1280, 12'd960, 16'sd0,      16'sd1,      1'b1, 18'sd0,      18'sd1},
        '{12'd0,    12'd0,   16'sd0,      16'sd0,      1'b0, 18'sd0,      18'sd0},
        '{12'd4095, 12'd4095, 16'sd0,     16'sd0,      1'b0, 18'sd0,      18'sd0},
        '{12'd4095, 12'd0,   16'sd32767,  16'sd32767,  1'b0, 18'sd0,      18'sd0},
        '{12'd0,    12'd4095, -16'sd32768, -16'sd32768, 1'b0, 18'sd0,     18'sd0},
        '{12'd2730, 12'd2730, 16'sd5461,  -16'sd5462,  1'b0, 18'sd0,      18'sd0},
        '{12'd1365, 12'd1365, -16'sd5462, 16'sd5461,   1'b0, 18'sd0,      18'sd0},
        '{12'd640,  12'd1500, 16'sd3000,  -16'sd3000,  1'b0, 18'sd0,      18'sd0}
    };

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) send_detection(directed[i]);
        i_valid <= 1'b0;
        drain_pipe();

        // reset values written back, with one long hold on the result side
        hold_req = 1'b1;
        run_phase(200, 16'd1200, 16'd1200, 16'd0, 16'd0, 16'd500, 16'd110, 16'd0, 16'd0);
        // upper extremes
        run_phase(80, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'd8191, 16'd1023,
                  16'd4095, 16'd4095);
        // lower extremes
        run_phase(80, 16'd0, 16'd0, 16'h8000, 16'h8000, 16'd0, 16'd0, 16'hF000, 16'hF000);
        // radius above lens height
        run_phase(80, 16'd900, 16'd1500, 16'd100, -16'sd200, 16'd50, 16'd1023, 16'd12, -16'sd7);
        // realistic settings, one of them with no idling
        quiet = 1'b1;
        run_phase(150, 16'd1000, 16'd1000, 16'd0, -16'sd300, 16'd600, 16'd110, 16'd40, 16'd0);
        quiet = 1'b0;
        repeat (3) begin
            run_phase(140, 16'($urandom_range(0, 4000)), 16'($urandom_range(0, 4000)),
                      16'(int'($urandom_range(0, 4000)) - 2000),
                      16'(int'($urandom_range(0, 4000)) - 2000),
                      16'($urandom_range(0, 8191)), 16'($urandom_range(0, 1023)),
                      16'($urandom), 16'($urandom));
        end

        $display("covered %0d detections over 8 register settings, %0d results checked",
                 n_items, n_results);
        $display("%0d results below the horizon, %0d field mismatches", n_on_ground, errors);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
+incdir+sv
sv/bgp_pkg.sv
sv/bgp_cordic.sv
sv/bgp_divider.sv
sv/ball_ground_position_unit.sv
sim/ball_ground_position_unit_test.sv
